@@ sv/assert_macros.svh @@
// assertion macros shared by the knob controller modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define KVM_ASSERT_AT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be seen at a rising edge outside reset
`define KVM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    `KVM_ASSERT_AT(name, clk, rst_n, !(cond), msg)

`endif

@@ sv/kvm_pkg.sv @@
// shared types, codes and constants of the knob volume and mode controller
// no dependencies; used by every module of the block
package kvm_pkg;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // input command codes
    localparam logic [2:0] CMD_CW     = 3'd0;
    localparam logic [2:0] CMD_CCW    = 3'd1;
    localparam logic [2:0] CMD_SHORT  = 3'd2;
    localparam logic [2:0] CMD_LONG   = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;
    localparam logic [2:0] CMD_SAMPLE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_GUARD = 2'd0;
    localparam logic [1:0] REG_HIDE  = 2'd1;
    localparam logic [1:0] REG_STEP  = 2'd2;

    // configuration reset values
    localparam logic [15:0] GUARD_RESET = 16'd500;
    localparam logic [15:0] HIDE_RESET  = 16'd3000;
    localparam logic [6:0]  STEP_RESET  = 7'd1;

    localparam logic [6:0]  FULL_VOLUME = 7'd100;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // floor(x/100) as (x*GAIN_RECIP)>>GAIN_SHIFT, exact for x <= 9801
    localparam logic [12:0] GAIN_RECIP = 13'd5243;
    localparam int unsigned GAIN_SHIFT = 19;
    // floor(a/100) as (a*DIV_RECIP)>>DIV_SHIFT, exact for a < 2^22
    localparam logic [22:0] DIV_RECIP  = 23'd5368710;
    localparam int unsigned DIV_SHIFT  = 29;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_CW,
        OP_CCW,
        OP_SHORT,
        OP_LONG,
        OP_TICK,
        OP_SAMPLE,
        OP_NOP
    } op_t;

    // player command codes
    typedef enum logic [1:0] {
        PC_NONE,
        PC_NEXT,
        PC_PREV,
        PC_TOGGLE
    } pc_t;

    // one queued item
    typedef struct packed {
        op_t                op;
        logic signed [15:0] sample;
    } item_t;

endpackage

@@ sv/kvm_front.sv @@
// front end: accepts items and classifies the command into an operation
// depends on kvm_pkg
module kvm_front (
    input  logic               push,
    output logic               full,
    input  logic [2:0]         cmd,
    input  logic signed [15:0] sample_in,
    input  logic               q_full,
    output logic               q_push,
    output kvm_pkg::item_t     q_item
);

    kvm_pkg::op_t op;

    // command decode
    always_comb
    begin
        unique case (cmd)
            kvm_pkg::CMD_CW:     op = kvm_pkg::OP_CW;
            kvm_pkg::CMD_CCW:    op = kvm_pkg::OP_CCW;
            kvm_pkg::CMD_SHORT:  op = kvm_pkg::OP_SHORT;
            kvm_pkg::CMD_LONG:   op = kvm_pkg::OP_LONG;
            kvm_pkg::CMD_TICK:   op = kvm_pkg::OP_TICK;
            kvm_pkg::CMD_SAMPLE: op = kvm_pkg::OP_SAMPLE;
            default:             op = kvm_pkg::OP_NOP;
        endcase
    end

    // sample payload only travels with sample items
    assign q_item.op     = op;
    assign q_item.sample = (op == kvm_pkg::OP_SAMPLE) ? sample_in : 16'sd0;

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

@@ sv/kvm_queue.sv @@
// short item queue between front and back
// depends on kvm_pkg for the item type
`include "assert_macros.svh"

module kvm_queue #(
    parameter int unsigned DEPTH = kvm_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kvm_pkg::item_t push_item,
    output logic           q_full,
    input  logic           take,
    output logic           q_empty,
    output kvm_pkg::item_t head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    kvm_pkg::item_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_take;

    assign q_full    = (count_reg == DEPTH_CNT);
    assign q_empty   = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !q_full;
    assign do_take   = take && !q_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_take)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_take && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `KVM_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > DEPTH_CNT, "queue overfilled")
    `KVM_ASSERT_AT(a_ptr_gap, clk, rst_n, (count_reg == '0 || count_reg == DEPTH_CNT) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")

endmodule

@@ sv/kvm_back.sv @@
// back end: knob state machine, gain refresh, sample scaling and result register
// depends on kvm_pkg
`include "assert_macros.svh"

module kvm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               q_empty,
    input  kvm_pkg::item_t     head_item,
    output logic               take,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         player_command,
    output logic               in_volume_mode,
    output logic [6:0]         volume_level,
    output logic               muted,
    output logic signed [15:0] sample_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_GAIN
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] guard_reg, hide_reg;
    logic [6:0]  step_reg;

    logic        mode_reg, mode_next;
    logic [6:0]  volume_reg, volume_next;
    logic        mute_reg, mute_next;
    logic [15:0] slp_reg, slp_next;
    logic [15:0] act_reg, act_next;

    logic [13:0]        sq_reg, sq_next;
    logic [6:0]         gain_reg, gain_next;
    logic signed [15:0] samp_reg, samp_next;
    logic signed [23:0] prod_reg, prod_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_pc_reg, out_pc_next;
    logic               out_mode_reg, out_mode_next;
    logic [6:0]         out_vol_reg, out_vol_next;
    logic               out_mute_reg, out_mute_next;
    logic signed [15:0] out_samp_reg, out_samp_next;

    logic               out_free;
    logic [7:0]         vol_sum;
    logic [6:0]         vol_up, vol_dn;
    logic [15:0]        slp_inc, act_inc;
    logic [26:0]        gain_prod;
    logic [22:0]        prod_mag;
    logic [45:0]        quot_prod;
    logic [14:0]        quot;
    logic signed [15:0] scaled;
    kvm_pkg::pc_t       pc;

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == ST_IDLE) && !q_empty && out_free;

    // volume stepping with clamp to 0..100
    assign vol_sum = {1'b0, volume_reg} + {1'b0, step_reg};
    assign vol_up  = (vol_sum > {1'b0, kvm_pkg::FULL_VOLUME}) ? kvm_pkg::FULL_VOLUME
                                                             : vol_sum[6:0];
    assign vol_dn  = (step_reg >= volume_reg) ? 7'd0 : volume_reg - step_reg;

    // saturating tick counters
    assign slp_inc = (slp_reg == kvm_pkg::COUNT_MAX) ? slp_reg : slp_reg + 16'd1;
    assign act_inc = (act_reg == kvm_pkg::COUNT_MAX) ? act_reg : act_reg + 16'd1;

    // gain = v*v/100 from the registered square
    assign gain_prod = 27'(sq_reg) * 27'(kvm_pkg::GAIN_RECIP);

    // product/100 truncating toward zero, via magnitude and reciprocal
    assign prod_mag  = prod_reg[23] ? 23'(-prod_reg) : 23'(prod_reg);
    assign quot_prod = 46'(prod_mag) * 46'(kvm_pkg::DIV_RECIP);
    assign quot      = quot_prod[kvm_pkg::DIV_SHIFT +: 15];
    assign scaled    = prod_reg[23] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    // next-state and result logic
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        volume_next    = volume_reg;
        mute_next      = mute_reg;
        slp_next       = slp_reg;
        act_next       = act_reg;
        sq_next        = sq_reg;
        gain_next      = gain_reg;
        samp_next      = samp_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !pop;
        out_pc_next    = out_pc_reg;
        out_mode_next  = out_mode_reg;
        out_vol_next   = out_vol_reg;
        out_mute_next  = out_mute_reg;
        out_samp_next  = out_samp_reg;
        pc             = kvm_pkg::PC_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (head_item.op) inside
                        kvm_pkg::OP_CW, kvm_pkg::OP_CCW:
                        begin
                            if (!mode_reg)
                            begin
                                pc = (head_item.op == kvm_pkg::OP_CW) ? kvm_pkg::PC_NEXT
                                                                     : kvm_pkg::PC_PREV;
                            end
                            else
                            begin
                                volume_next = (head_item.op == kvm_pkg::OP_CW) ? vol_up
                                                                              : vol_dn;
                                mute_next   = 1'b0;
                                act_next    = '0;
                                state_next  = ST_SQ;
                            end
                        end
                        kvm_pkg::OP_SHORT:
                        begin
                            if (slp_reg >= guard_reg)
                            begin
                                if (!mode_reg)
                                begin
                                    pc = kvm_pkg::PC_TOGGLE;
                                end
                                else
                                begin
                                    mute_next = !mute_reg;
                                    act_next  = '0;
                                end
                            end
                        end
                        kvm_pkg::OP_LONG:
                        begin
                            slp_next  = '0;
                            mode_next = !mode_reg;
                            if (!mode_reg)
                            begin
                                act_next = '0;
                            end
                        end
                        kvm_pkg::OP_TICK:
                        begin
                            slp_next = slp_inc;
                            act_next = act_inc;
                            if (mode_reg && act_inc >= hide_reg)
                            begin
                                mode_next = 1'b0;
                            end
                        end
                        kvm_pkg::OP_SAMPLE:
                        begin
                            samp_next  = head_item.sample;
                            prod_next  = 24'(head_item.sample)
                                         * 24'($signed({1'b0, gain_reg}));
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                        end
                    endcase

                    // every operation but a sample reports at once
                    if (head_item.op != kvm_pkg::OP_SAMPLE)
                    begin
                        out_valid_next = 1'b1;
                        out_pc_next    = pc;
                        out_mode_next  = mode_next;
                        out_vol_next   = volume_next;
                        out_mute_next  = mute_next;
                        out_samp_next  = '0;
                    end
                end
            end
            ST_DIV:
            begin
                out_valid_next = 1'b1;
                out_pc_next    = kvm_pkg::PC_NONE;
                out_mode_next  = mode_reg;
                out_vol_next   = volume_reg;
                out_mute_next  = mute_reg;
                if (mute_reg || volume_reg == 7'd0)
                begin
                    out_samp_next = '0;
                end
                else if (volume_reg >= kvm_pkg::FULL_VOLUME)
                begin
                    out_samp_next = samp_reg;
                end
                else
                begin
                    out_samp_next = scaled;
                end
                state_next = ST_IDLE;
            end
            ST_SQ:
            begin
                sq_next    = 14'(volume_reg) * 14'(volume_reg);
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                gain_next  = gain_prod[kvm_pkg::GAIN_SHIFT +: 7];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            guard_reg     <= kvm_pkg::GUARD_RESET;
            hide_reg      <= kvm_pkg::HIDE_RESET;
            step_reg      <= kvm_pkg::STEP_RESET;
            mode_reg      <= 1'b0;
            volume_reg    <= kvm_pkg::FULL_VOLUME;
            mute_reg      <= 1'b0;
            slp_reg       <= '0;
            act_reg       <= '0;
            sq_reg        <= '0;
            gain_reg      <= kvm_pkg::FULL_VOLUME;
            samp_reg      <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_pc_reg    <= '0;
            out_mode_reg  <= 1'b0;
            out_vol_reg   <= '0;
            out_mute_reg  <= 1'b0;
            out_samp_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            volume_reg    <= volume_next;
            mute_reg      <= mute_next;
            slp_reg       <= slp_next;
            act_reg       <= act_next;
            sq_reg        <= sq_next;
            gain_reg      <= gain_next;
            samp_reg      <= samp_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            out_pc_reg    <= out_pc_next;
            out_mode_reg  <= out_mode_next;
            out_vol_reg   <= out_vol_next;
            out_mute_reg  <= out_mute_next;
            out_samp_reg  <= out_samp_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    kvm_pkg::REG_GUARD: guard_reg <= cfg_data;
                    kvm_pkg::REG_HIDE:  hide_reg  <= cfg_data;
                    kvm_pkg::REG_STEP:  step_reg  <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign empty          = !out_valid_reg;
    assign player_command = out_pc_reg;
    assign in_volume_mode = out_mode_reg;
    assign volume_level   = out_vol_reg;
    assign muted          = out_mute_reg;
    assign sample_out     = out_samp_reg;

    `KVM_ASSERT_NEVER(a_volume_range, clk, rst_n, volume_reg > kvm_pkg::FULL_VOLUME, "volume above full scale")
    `KVM_ASSERT_AT(a_div_slot_free, clk, rst_n, (state_reg == ST_DIV) |-> !out_valid_reg, "sample result would overwrite a waiting item")
    `KVM_ASSERT_AT(a_gain_refresh, clk, rst_n, (state_reg == ST_SQ) |=> (state_reg == ST_GAIN), "gain refresh interrupted")

endmodule

@@ sv/knob_volume_mode_controller.sv @@
// top level of the knob volume and mode controller
// depends on kvm_pkg, kvm_front, kvm_queue and kvm_back
//
// Input side is a queue: an item (cmd, sample_in) is taken at a rising edge
//   with push high and full low. Commands: rotate cw/ccw, short press, long
//   press, tick, sample.
// Result side is a queue: while empty is low the result ports hold the oldest
//   result; it is taken at a rising edge with pop high. One result per item.
// Configuration: cfg_wr_en with cfg_index (0 guard ticks, 1 hide ticks,
//   2 volume step size) and cfg_data writes a register at the edge; other
//   indexes are ignored. Write only while the block is idle.
// Execution: a knob or tick result is registered as the item is taken, a sample
//   result after the product register (multiply, then divide by 100 via
//   reciprocal). The back end runs one item at a time; a volume-mode rotation
//   also passes SQ and GAIN (gain v*v/100 is refreshed), a sample DIV. A
//   QUEUE_DEPTH-entry queue separates classification from execution.
// Reset empties the queue and result slot and restores track mode, volume
//   100, unmuted, zeroed counters and default configuration. While a result waits
//   and pop is low it holds, no item is taken, and full rises once the queue fills.
module knob_volume_mode_controller #(
    parameter int unsigned QUEUE_DEPTH = kvm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         cmd,
    input  logic signed [15:0] sample_in,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         player_command,
    output logic               in_volume_mode,
    output logic [6:0]         volume_level,
    output logic               muted,
    output logic signed [15:0] sample_out,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic           q_full, q_push, q_empty, take;
    kvm_pkg::item_t q_item, head_item;

    // classification
    kvm_front u_front (
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .sample_in (sample_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // decoupling queue
    kvm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .q_full    (q_full),
        .take      (take),
        .q_empty   (q_empty),
        .head_item (head_item)
    );

    // execution and result register
    kvm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_empty        (q_empty),
        .head_item      (head_item),
        .take           (take),
        .empty          (empty),
        .pop            (pop),
        .player_command (player_command),
        .in_volume_mode (in_volume_mode),
        .volume_level   (volume_level),
        .muted          (muted),
        .sample_out     (sample_out)
    );

endmodule
